// ----- rtl/srf_pkg.sv -----
// Shared types and constants for the sequenced ring FIFO.
// Used by srf_ctrl, srf_datapath and sequenced_ring_fifo_unit; no dependencies.
package srf_pkg;

  localparam int DefaultMaxEntries = 256;
  localparam int CapW              = 9;
  localparam int WordW             = 32;
  localparam int InDataW           = 64;
  localparam int OutDataW          = 216;
  localparam int StatW             = 2;

  typedef enum logic [StatW-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } req_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

  typedef struct packed {
    logic [WordW-1:0] seq;
    logic [WordW-1:0] stamp;
    logic [WordW-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic    enq_commit;
    logic    deq_issue;
    logic    load_out;
    logic    use_rd;
    status_e status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

// ----- rtl/srf_ctrl.sv -----
// Request sequencer for the sequenced ring FIFO: input handshake, read wait, output valid.
// Depends on srf_pkg.
module srf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic              req_type_i,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  srf_pkg::dp_stat_t stat_i,
  output srf_pkg::ctrl_cmd_t cmd_o
);
  import srf_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;
  logic   accept;

  assign slot_free     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && slot_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (req_e'(req_type_i) == REQ_DEQ) && !stat_i.empty) begin
          state_d = S_READ;
        end
      end
      S_READ:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '{enq_commit: 1'b0, deq_issue: 1'b0, load_out: 1'b0, use_rd: 1'b0,
              status: ST_DONE};
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_e'(req_type_i) == REQ_ENQ) begin
            cmd_o.load_out = 1'b1;
            if (stat_i.full) begin
              cmd_o.status = ST_FULL;
            end else begin
              cmd_o.enq_commit = 1'b1;
            end
          end else if (stat_i.empty) begin
            cmd_o.load_out = 1'b1;
            cmd_o.status   = ST_EMPTY;
          end else begin
            cmd_o.deq_issue = 1'b1;
          end
        end
      end
      S_READ: begin
        cmd_o.load_out = 1'b1;
        cmd_o.use_rd   = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTH
  a_read_completes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.deq_issue |=> (cmd_o.load_out && cmd_o.use_rd))
    else $error("dequeue read not followed by result load");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> m_axis_tvalid)
    else $error("loaded result not presented");
`endif

endmodule

// ----- rtl/srf_datapath.sv -----
// Datapath of the sequenced ring FIFO: entry memory, pointers, counters, result register.
// Depends on srf_pkg; driven by srf_ctrl commands.
module srf_datapath #(
  parameter int MAX_ENTRIES = srf_pkg::DefaultMaxEntries
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  srf_pkg::ctrl_cmd_t           cmd_i,
  output srf_pkg::dp_stat_t            stat_o,
  input  logic                         cfg_valid_i,
  input  logic [srf_pkg::CapW-1:0]     cfg_data_i,
  input  logic [srf_pkg::WordW-1:0]    in_time_i,
  input  logic [srf_pkg::WordW-1:0]    in_handle_i,
  output logic [srf_pkg::OutDataW-1:0] out_data_o,
  output logic [srf_pkg::StatW-1:0]    out_status_o
);
  import srf_pkg::*;

  localparam int PtrW     = $clog2(MAX_ENTRIES);
  localparam int CmpW     = (PtrW + 1 > CapW) ? PtrW + 1 : CapW;
  localparam int CapLimit = (MAX_ENTRIES < 511) ? MAX_ENTRIES : 511;
  localparam int CapReset = (CapLimit < 256) ? CapLimit : 256;
  localparam int PadW     = OutDataW - 6 * WordW - 2 * CapW;

  entry_t mem [MAX_ENTRIES];
  entry_t rd_q;

  logic [PtrW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [CapW-1:0]  fill_q, fill_d, cap_q, cap_d;
  logic [WordW-1:0] seq_q, seq_d, ins_q, ins_d, rem_q, rem_d;
  logic [CapW-1:0]  cfg_clamped;
  entry_t           res_entry;

  function automatic logic [PtrW-1:0] advance(input logic [PtrW-1:0] p,
                                              input logic [CapW-1:0] cap);
    logic [CmpW-1:0] n;
    n = CmpW'(p) + CmpW'(1);
    return (n >= CmpW'(cap)) ? '0 : n[PtrW-1:0];
  endfunction

  assign stat_o.full  = (fill_q >= cap_q);
  assign stat_o.empty = (fill_q == '0);

  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_clamped = CapW'(1);
    end else if (cfg_data_i > CapW'(CapLimit)) begin
      cfg_clamped = CapW'(CapLimit);
    end else begin
      cfg_clamped = cfg_data_i;
    end
  end

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    fill_d = fill_q;
    cap_d  = cap_q;
    seq_d  = seq_q;
    ins_d  = ins_q;
    rem_d  = rem_q;
    if (cmd_i.enq_commit) begin
      tail_d = advance(tail_q, cap_q);
      fill_d = fill_q + CapW'(1);
      seq_d  = seq_q + WordW'(1);
      ins_d  = ins_q + WordW'(1);
    end else if (cmd_i.deq_issue) begin
      head_d = advance(head_q, cap_q);
      fill_d = fill_q - CapW'(1);
      rem_d  = rem_q + WordW'(1);
    end else if (cfg_valid_i && (fill_q == '0)) begin
      cap_d  = cfg_clamped;
      head_d = '0;
      tail_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
      cap_q  <= CapW'(CapReset);
      seq_q  <= '0;
      ins_q  <= '0;
      rem_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
      cap_q  <= cap_d;
      seq_q  <= seq_d;
      ins_q  <= ins_d;
      rem_q  <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.enq_commit) begin
      mem[tail_q] <= '{seq: seq_q, stamp: in_time_i, handle: in_handle_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.deq_issue) begin
      rd_q <= mem[head_q];
    end
  end

  assign res_entry = cmd_i.use_rd ? rd_q : '0;

  // result fields, highest first
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_o <= cmd_i.status;
      out_data_o   <= {{PadW{1'b0}}, rem_d, ins_d, cap_d - fill_d, fill_d, seq_d,
                       res_entry.handle, res_entry.stamp, res_entry.seq};
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= cap_q)
    else $error("fill level above capacity");

  a_single_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.enq_commit && cmd_i.deq_issue))
    else $error("enqueue and dequeue in one cycle");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CmpW'(head_q) < CmpW'(cap_q)) && (CmpW'(tail_q) < CmpW'(cap_q)))
    else $error("pointer outside capacity");
`endif

endmodule

// ----- rtl/sequenced_ring_fifo_unit.sv -----
// Sequenced ring FIFO, top level.
// Requests enter on the s_axis channel: tuser selects enqueue (0) or dequeue (1),
// tdata carries the timestamp and message handle stored by an enqueue.
// Every request yields one result on m_axis: tuser holds the status code
// (done, refused because full, refused because empty), tdata the dequeued entry
// and the counters after the request. Capacity is written on the cfg channel,
// only while the queue is empty and no enqueue commits with it; other writes are ignored.
// An enqueue or a refused request gives its result in the cycle after acceptance;
// a successful dequeue's result is loaded after the registered memory read, in S_READ.
// Throughput: one request per cycle for enqueues and refusals while results are taken;
// during a successful dequeue's read on the single read port no new request is taken.
// Reset empties the queue, clears pointers and counters and sets the capacity
// to 256 or MAX_ENTRIES if smaller; entry contents are not cleared.
// While a result waits on a stalled receiver it is held, and a new request is
// taken only in the cycle the result is taken.
// Depends on srf_pkg, srf_ctrl, srf_datapath.
module sequenced_ring_fifo_unit #(
  parameter int MAX_ENTRIES = srf_pkg::DefaultMaxEntries
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [31:0] item_time, [63:32] msg_handle
  input  logic [srf_pkg::InDataW-1:0]  s_axis_tdata,
  // [0] req_type
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [31:0] out_seq, [63:32] out_time, [95:64] out_handle, [127:96] next_sequence,
  // [136:128] stored_count, [145:137] free_count, [177:146] insert_total,
  // [209:178] removal_total, [215:210] zero
  output logic [srf_pkg::OutDataW-1:0] m_axis_tdata,
  // [1:0] status
  output logic [srf_pkg::StatW-1:0]    m_axis_tuser,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [srf_pkg::CapW-1:0]     cfg_data_i
);
  import srf_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready_o = 1'b1;

  srf_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .req_type_i    (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  srf_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .in_time_i    (s_axis_tdata[WordW-1:0]),
    .in_handle_i  (s_axis_tdata[InDataW-1:WordW]),
    .out_data_o   (m_axis_tdata),
    .out_status_o (m_axis_tuser)
  );

endmodule
